>>> rtl/asad_pkg.sv
// Shared types and constants for the sorting collector.
`timescale 1ns / 1ps
package asad_pkg;

   localparam int unsigned VALUE_W = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT_DOWN,
      CELL_SHIFT_UP
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_EMIT_ASC,
      ST_ALIGN,
      ST_EMIT_DESC
   } state_type;

   typedef struct packed {
      cell_op_type op;
      value_type   key;
   } cell_ctl_type;

   typedef struct packed {
      value_type value;
      logic      occ;
      logic      gt;
   } cell_link_type;

endpackage

>>> rtl/asad_req_if.sv
// Request channel: one element of a set per request.
`timescale 1ns / 1ps
interface asad_req_if;
   logic                valid;
   logic                ready;
   asad_pkg::value_type value_in;
   logic                last_in;

   modport source (output valid, output value_in, output last_in, input ready);
   modport sink (input valid, input value_in, input last_in, output ready);
endinterface

>>> rtl/asad_rsp_if.sv
// Response channel: one sorted element per response.
`timescale 1ns / 1ps
interface asad_rsp_if;
   logic                valid;
   logic                ready;
   asad_pkg::value_type sorted_value;
   logic                last_out;
   logic                dropped;

   modport source (output valid, output sorted_value, output last_out, output dropped,
                   input ready);
   modport sink (input valid, input sorted_value, input last_out, input dropped,
                 output ready);
endinterface

>>> rtl/asad_cell.sv
// One cell of the sorting chain: holds a value and trades it with its neighbours.
`timescale 1ns / 1ps
module asad_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  asad_pkg::cell_ctl_type  ctl,
   input  asad_pkg::cell_link_type below,
   input  asad_pkg::cell_link_type above,
   output asad_pkg::cell_link_type link
);

   asad_pkg::value_type value_ff, value_in;
   logic                occ_ff, occ_in;
   logic                gt;

   assign gt = !occ_ff || (value_ff > ctl.key);

   always_comb begin
      value_in = value_ff;
      occ_in   = occ_ff;
      case (ctl.op)
         asad_pkg::CELL_INSERT: begin
            if (gt) begin
               value_in = below.gt ? below.value : ctl.key;
               occ_in   = occ_ff | below.occ;
            end
         end
         asad_pkg::CELL_SHIFT_DOWN: begin
            value_in = above.value;
            occ_in   = above.occ;
         end
         asad_pkg::CELL_SHIFT_UP: begin
            value_in = below.value;
            occ_in   = below.occ;
         end
         default: begin
            value_in = value_ff;
            occ_in   = occ_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign link.value = value_ff;
   assign link.occ   = occ_ff;
   assign link.gt    = gt;

endmodule

>>> rtl/array_sort_asc_desc.sv
// Top level of the sorting collector: cell chain, sequencer and response register.
`timescale 1ns / 1ps
// Collects a set of signed 32-bit values, one per request, into a chain of DEPTH
// cells that keeps them in ascending order as they arrive; ready stays high
// while loading. Requests beyond DEPTH are discarded and flagged on every
// response of the set. The request marked last starts the emission: ascending
// order streams out of the bottom cell at one response per cycle while
// responses are taken; descending order first shifts the chain up until the top
// cell is full (DEPTH minus the number of values held shifts) and then streams
// out of the top cell at one response per cycle while responses are taken. The
// order bit is sampled when the last request is accepted. No request is taken
// from the last request of a set until the final response is in the output reg.
module array_sort_asc_desc #(
   parameter int unsigned DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data,
   asad_req_if.sink          req_if,
   asad_rsp_if.source        rsp_if
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   asad_pkg::state_type     state_ff, state_in;
   logic [CNT_W-1:0]        fill_count_ff, fill_count_in;
   logic                    overflow_ff, overflow_in;
   logic                    desc_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   asad_pkg::value_type     rsp_value_ff;
   logic                    rsp_last_ff;
   logic                    rsp_dropped_ff;

   asad_pkg::cell_ctl_type  ctl;
   asad_pkg::cell_link_type link [DEPTH];
   asad_pkg::cell_link_type bottom_link, top_link;
   logic [DEPTH-1:0]        occ_vec;

   logic accept, full, take, rsp_load, final_load;
   asad_pkg::value_type emit_value;

   assign accept     = req_if.valid && req_if.ready;
   assign full       = (fill_count_ff == CNT_FULL);
   assign take       = !rsp_valid_ff || rsp_if.ready;
   assign final_load = rsp_load && (fill_count_ff == CNT_ONE);

   // the chain
   always_comb begin
      bottom_link.value = '0;
      bottom_link.occ   = (ctl.op == asad_pkg::CELL_INSERT);
      bottom_link.gt    = 1'b0;
      top_link.value    = '0;
      top_link.occ      = 1'b0;
      top_link.gt       = 1'b1;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      asad_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .below ((i == 0) ? bottom_link : link[(i == 0) ? 0 : i - 1]),
         .above ((i == DEPTH - 1) ? top_link : link[(i == DEPTH - 1) ? i : i + 1]),
         .link  (link[i])
      );
      assign occ_vec[i] = link[i].occ;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         asad_pkg::ST_LOAD: begin
            if (accept && req_if.last_in) begin
               state_in = desc_ff ? asad_pkg::ST_ALIGN : asad_pkg::ST_EMIT_ASC;
            end
         end
         asad_pkg::ST_EMIT_ASC: begin
            if (final_load) begin
               state_in = asad_pkg::ST_LOAD;
            end
         end
         asad_pkg::ST_ALIGN: begin
            if (link[DEPTH-1].occ) begin
               state_in = asad_pkg::ST_EMIT_DESC;
            end
         end
         asad_pkg::ST_EMIT_DESC: begin
            if (final_load) begin
               state_in = asad_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = asad_pkg::ST_LOAD;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_if.ready = 1'b0;
      ctl.op       = asad_pkg::CELL_HOLD;
      ctl.key      = req_if.value_in;
      rsp_load     = 1'b0;
      emit_value   = link[0].value;
      case (state_ff)
         asad_pkg::ST_LOAD: begin
            req_if.ready = 1'b1;
            if (req_if.valid && !full) begin
               ctl.op = asad_pkg::CELL_INSERT;
            end
         end
         asad_pkg::ST_EMIT_ASC: begin
            if (take) begin
               ctl.op   = asad_pkg::CELL_SHIFT_DOWN;
               rsp_load = 1'b1;
            end
         end
         asad_pkg::ST_ALIGN: begin
            if (!link[DEPTH-1].occ) begin
               ctl.op = asad_pkg::CELL_SHIFT_UP;
            end
         end
         asad_pkg::ST_EMIT_DESC: begin
            emit_value = link[DEPTH-1].value;
            if (take) begin
               ctl.op   = asad_pkg::CELL_SHIFT_UP;
               rsp_load = 1'b1;
            end
         end
         default: begin
            req_if.ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      fill_count_in = fill_count_ff;
      overflow_in   = overflow_ff;
      if (accept && !full) begin
         fill_count_in = fill_count_ff + CNT_ONE;
      end
      if (accept && full) begin
         overflow_in = 1'b1;
      end
      if (rsp_load) begin
         fill_count_in = fill_count_ff - CNT_ONE;
      end
      if (final_load) begin
         overflow_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= asad_pkg::ST_LOAD;
         fill_count_ff <= '0;
         overflow_ff   <= 1'b0;
         desc_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         overflow_ff   <= overflow_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            desc_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff   <= emit_value;
         rsp_last_ff    <= (fill_count_ff == CNT_ONE);
         rsp_dropped_ff <= overflow_ff;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.sorted_value = rsp_value_ff;
   assign rsp_if.last_out     = rsp_last_ff;
   assign rsp_if.dropped      = rsp_dropped_ff;

   a_count_matches_cells : assert property (@(posedge clock) disable iff (reset)
      $countones(occ_vec) == 32'(fill_count_ff))
      else $error("fill count disagrees with occupied cells");

   a_fill_bounded : assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CNT_FULL)
      else $error("fill count beyond capacity");

   a_packed_low : assert property (@(posedge clock) disable iff (reset)
      (state_ff == asad_pkg::ST_LOAD || state_ff == asad_pkg::ST_EMIT_ASC)
         |-> ((occ_vec & (occ_vec + DEPTH'(1))) == '0))
      else $error("occupied cells not packed at the bottom");

   a_emit_nonempty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == asad_pkg::ST_EMIT_ASC || state_ff == asad_pkg::ST_EMIT_DESC
         || state_ff == asad_pkg::ST_ALIGN) |-> (fill_count_ff != '0))
      else $error("emission with an empty chain");

   a_drop_clear : assert property (@(posedge clock) disable iff (reset)
      final_load |=> !overflow_ff)
      else $error("drop flag survives the end of a set");

endmodule
